// ----- design/lrult_pkg.sv -----
// lrult_pkg: shared constants, types and sequencer states of the lru lookup table
`default_nettype none

package lrult_pkg;

	// table geometry
	localparam int unsigned DEPTH   = 128;
	localparam int unsigned IDX_W   = $clog2(DEPTH);
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned REF_W   = 32;
	localparam int unsigned SIZE_W  = 32;
	localparam int unsigned DATA_W  = REF_W + SIZE_W;
	localparam int unsigned LIMIT_W = 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_e_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_INS_RD,
		ST_INS_WR,
		ST_SHIFT_START,
		ST_SHIFT_WR,
		ST_FRONT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              opcode;
		logic [KEY_W-1:0]  path_key;
		logic [REF_W-1:0]  content_ref;
		logic [SIZE_W-1:0] content_size;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [REF_W-1:0]  found_ref;
		logic [SIZE_W-1:0] found_size;
		logic [CNT_W-1:0]  evicted_count;
		logic [CNT_W-1:0]  entries_held;
	} rsp_t;

	// sequencer status toward the channel logic
	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

endpackage

`default_nettype wire

// ----- design/lrult_if.sv -----
// lrult_if: valid/ready channel interfaces for request, response and configuration
`default_nettype none

interface lrult_req_if;
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [lrult_pkg::KEY_W-1:0]    path_key;
	logic [lrult_pkg::REF_W-1:0]    content_ref;
	logic [lrult_pkg::SIZE_W-1:0]   content_size;

	modport source (output valid, output opcode, output path_key, output content_ref,
		output content_size, input ready);
	modport sink (input valid, input opcode, input path_key, input content_ref,
		input content_size, output ready);
endinterface

interface lrult_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           hit;
	logic [lrult_pkg::REF_W-1:0]    found_ref;
	logic [lrult_pkg::SIZE_W-1:0]   found_size;
	logic [lrult_pkg::CNT_W-1:0]    evicted_count;
	logic [lrult_pkg::CNT_W-1:0]    entries_held;

	modport source (output valid, output hit, output found_ref, output found_size,
		output evicted_count, output entries_held, input ready);
	modport sink (input valid, input hit, input found_ref, input found_size,
		input evicted_count, input entries_held, output ready);
endinterface

interface lrult_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lrult_pkg::LIMIT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lru_lookup_table.sv -----
// lru_lookup_table: top level with request, response and limit channels
//
// Fully associative table of up to 128 entries kept in recency order.
// req carries one beat per item: opcode 0 looks up path_key, opcode 1
// inserts path_key with content_ref and content_size at the front.
// rsp returns one beat per item: hit, found_ref, found_size (zero on a
// miss or an insert), evicted_count and entries_held after the item.
// cfg writes entry_limit (reset 100; 0 acts as 1, above 128 as 128);
// write it only while the block is idle. A lower limit takes effect at
// the next insert.
// Timing: one item at a time; req.ready is high only when idle. A lookup
// walks the recency list one position a cycle through a two-deep read
// pipeline and, on a hit, then shifts the list one position a cycle.
// An insert shifts the list the same way. The recency list memory has
// one read and one write port. The result sits in an output register;
// a stalled receiver holds the block in its final state until rsp is
// free.
// Reset (arst_n low) empties the table and restores the limit.
`default_nettype none

module lru_lookup_table (
	input  logic        clk,
	input  logic        arst_n,
	lrult_req_if.sink   req,
	lrult_rsp_if.source rsp,
	lrult_cfg_if.sink   cfg
);

	logic [lrult_pkg::LIMIT_W-1:0] limit_q;
	lrult_pkg::req_t               req_beat;
	lrult_pkg::rsp_t               result;
	lrult_pkg::rsp_t               rsp_q;
	lrult_pkg::seq_stat_t          stat;
	logic                          start;
	logic                          take;
	logic                          rsp_valid_q;

	// limit register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lrult_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.data;
		end
	end

	// request beat
	assign req.ready             = stat.idle;
	assign start                 = req.valid && stat.idle;
	assign req_beat.opcode       = req.opcode;
	assign req_beat.path_key     = req.path_key;
	assign req_beat.content_ref  = req.content_ref;
	assign req_beat.content_size = req.content_size;

	lrult_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req_in(req_beat),
		.limit (limit_q),
		.take  (take),
		.stat  (stat),
		.result(result)
	);

	// output register
	assign take = !rsp_valid_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done && take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && take) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_q.hit;
	assign rsp.found_ref     = rsp_q.found_ref;
	assign rsp.found_size    = rsp_q.found_size;
	assign rsp.evicted_count = rsp_q.evicted_count;
	assign rsp.entries_held  = rsp_q.entries_held;

endmodule

`default_nettype wire

// ----- design/lrult_ram.sv -----
// lrult_ram: generic single write port ram with one registered read port
`default_nettype none

module lrult_ram #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/lrult_seq.sv -----
// lrult_seq: sequencer, key compare unit and table memories of the lru lookup table
`default_nettype none

module lrult_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  lrult_pkg::req_t                req_in,
	input  logic [lrult_pkg::LIMIT_W-1:0]  limit,
	input  logic                           take,
	output lrult_pkg::seq_stat_t           stat,
	output lrult_pkg::rsp_t                result
);

	localparam int unsigned IDX_W = lrult_pkg::IDX_W;
	localparam int unsigned CNT_W = lrult_pkg::CNT_W;

	lrult_pkg::state_t state_q, state_d;

	// control state
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] hw_q;
	logic [CNT_W-1:0] iss_q;
	logic             v_s1, v_s2;

	// item and result registers
	logic [lrult_pkg::KEY_W-1:0]  key_q;
	logic [lrult_pkg::REF_W-1:0]  ref_q;
	logic [lrult_pkg::SIZE_W-1:0] size_q;
	logic                         hit_q;
	logic [lrult_pkg::REF_W-1:0]  fref_q;
	logic [lrult_pkg::SIZE_W-1:0] fsize_q;
	logic [CNT_W-1:0]             evict_q;
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             slot_q;
	logic [IDX_W-1:0]             pos_s2;
	logic [IDX_W-1:0]             slot_s2;
	logic [IDX_W-1:0]             ord_addr_q;
	logic                         ord_ident_q;

	// memory ports
	logic                          ord_we;
	logic [IDX_W-1:0]              ord_waddr, ord_wdata, ord_raddr, ord_rdata;
	logic                          tab_we;
	logic [IDX_W-1:0]              tab_waddr, tab_raddr;
	logic [lrult_pkg::KEY_W-1:0]   key_rdata;
	logic [lrult_pkg::DATA_W-1:0]  data_rdata;

	// helpers
	logic [IDX_W-1:0] order_slot;
	logic [IDX_W-1:0] ins_pos;
	logic             iss_more;
	logic             key_match;
	logic             scan_hit;
	logic             scan_miss;
	logic [CNT_W-1:0] eff_limit;
	logic [CNT_W-1:0] total;
	logic [CNT_W-1:0] new_count;

	// positions never written still hold their own index
	assign order_slot = ord_ident_q ? ord_addr_q : ord_rdata;
	assign iss_more   = iss_q < count_q;
	assign key_match  = v_s2 && (key_rdata == key_q);
	assign scan_hit   = (state_q == lrult_pkg::ST_SCAN) && key_match;
	assign scan_miss  = (state_q == lrult_pkg::ST_SCAN) && !key_match && !v_s1 && !v_s2
		&& !iss_more;
	assign ins_pos    = (count_q < CNT_W'(lrult_pkg::DEPTH)) ? count_q[IDX_W-1:0]
		: IDX_W'(lrult_pkg::DEPTH - 1);

	// limit clamp and eviction count
	always_comb begin
		if (limit == '0) begin
			eff_limit = CNT_W'(1);
		end else if (limit > CNT_W'(lrult_pkg::DEPTH)) begin
			eff_limit = CNT_W'(lrult_pkg::DEPTH);
		end else begin
			eff_limit = limit;
		end
		total     = count_q + CNT_W'(1);
		new_count = (total > eff_limit) ? eff_limit : total;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lrult_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (req_in.opcode == lrult_pkg::OP_INSERT) ? lrult_pkg::ST_INS_RD
						: lrult_pkg::ST_SCAN;
				end
			end
			lrult_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_d = lrult_pkg::ST_SHIFT_START;
				end else if (scan_miss) begin
					state_d = lrult_pkg::ST_DONE;
				end
			end
			lrult_pkg::ST_INS_RD:      state_d = lrult_pkg::ST_INS_WR;
			lrult_pkg::ST_INS_WR:      state_d = lrult_pkg::ST_SHIFT_START;
			lrult_pkg::ST_SHIFT_START: begin
				state_d = (idx_q == '0) ? lrult_pkg::ST_FRONT : lrult_pkg::ST_SHIFT_WR;
			end
			lrult_pkg::ST_SHIFT_WR: begin
				if (idx_q == IDX_W'(1)) begin
					state_d = lrult_pkg::ST_FRONT;
				end
			end
			lrult_pkg::ST_FRONT:       state_d = lrult_pkg::ST_DONE;
			lrult_pkg::ST_DONE: begin
				if (take) begin
					state_d = lrult_pkg::ST_IDLE;
				end
			end
			default:                   state_d = lrult_pkg::ST_IDLE;
		endcase
	end

	// memory port control per state
	always_comb begin
		ord_raddr = '0;
		ord_we    = 1'b0;
		ord_waddr = idx_q;
		ord_wdata = order_slot;
		tab_we    = 1'b0;
		tab_waddr = order_slot;
		tab_raddr = order_slot;
		case (state_q)
			lrult_pkg::ST_SCAN:        ord_raddr = iss_q[IDX_W-1:0];
			lrult_pkg::ST_INS_RD:      ord_raddr = ins_pos;
			lrult_pkg::ST_INS_WR:      tab_we = 1'b1;
			lrult_pkg::ST_SHIFT_START: ord_raddr = idx_q - IDX_W'(1);
			lrult_pkg::ST_SHIFT_WR: begin
				ord_we    = 1'b1;
				ord_raddr = idx_q - IDX_W'(2);
			end
			lrult_pkg::ST_FRONT: begin
				ord_we    = 1'b1;
				ord_waddr = '0;
				ord_wdata = slot_q;
			end
			default: begin
				ord_raddr = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrult_pkg::ST_IDLE;
			count_q <= '0;
			hw_q    <= '0;
			iss_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == lrult_pkg::ST_SCAN) && iss_more && !scan_hit;
			v_s2    <= (state_q == lrult_pkg::ST_SCAN) && v_s1 && !scan_hit;
			if (state_q == lrult_pkg::ST_IDLE) begin
				iss_q <= '0;
			end else if ((state_q == lrult_pkg::ST_SCAN) && iss_more) begin
				iss_q <= iss_q + CNT_W'(1);
			end
			if (state_q == lrult_pkg::ST_INS_WR) begin
				count_q <= new_count;
			end
			// high-water mark of written recency positions
			if ((state_q == lrult_pkg::ST_SHIFT_START)
				&& ({1'b0, idx_q} + CNT_W'(1) > hw_q)) begin
				hw_q <= {1'b0, idx_q} + CNT_W'(1);
			end
		end
	end

	// item, pipeline and result registers
	always_ff @(posedge clk) begin
		ord_addr_q  <= ord_raddr;
		ord_ident_q <= ({1'b0, ord_raddr} >= hw_q);
		if (v_s1) begin
			pos_s2  <= ord_addr_q;
			slot_s2 <= order_slot;
		end
		case (state_q)
			lrult_pkg::ST_IDLE: begin
				if (start) begin
					key_q   <= req_in.path_key;
					ref_q   <= req_in.content_ref;
					size_q  <= req_in.content_size;
					hit_q   <= 1'b0;
					fref_q  <= '0;
					fsize_q <= '0;
					evict_q <= '0;
				end
			end
			lrult_pkg::ST_SCAN: begin
				if (scan_hit) begin
					hit_q   <= 1'b1;
					fref_q  <= data_rdata[lrult_pkg::DATA_W-1 -: lrult_pkg::REF_W];
					fsize_q <= data_rdata[lrult_pkg::SIZE_W-1:0];
					slot_q  <= slot_s2;
					idx_q   <= pos_s2;
				end
			end
			lrult_pkg::ST_INS_RD: idx_q <= ins_pos;
			lrult_pkg::ST_INS_WR: begin
				slot_q  <= order_slot;
				evict_q <= total - new_count;
			end
			lrult_pkg::ST_SHIFT_WR: idx_q <= idx_q - IDX_W'(1);
			default: begin
				hit_q <= hit_q;
			end
		endcase
	end

	// recency order: slot held at each position
	lrult_ram #(
		.DEPTH(lrult_pkg::DEPTH),
		.WIDTH(IDX_W)
	) u_order_ram (
		.clk  (clk),
		.we   (ord_we),
		.waddr(ord_waddr),
		.wdata(ord_wdata),
		.raddr(ord_raddr),
		.rdata(ord_rdata)
	);

	// keys by slot
	lrult_ram #(
		.DEPTH(lrult_pkg::DEPTH),
		.WIDTH(lrult_pkg::KEY_W)
	) u_key_ram (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata(key_q),
		.raddr(tab_raddr),
		.rdata(key_rdata)
	);

	// reference and size by slot
	lrult_ram #(
		.DEPTH(lrult_pkg::DEPTH),
		.WIDTH(lrult_pkg::DATA_W)
	) u_data_ram (
		.clk  (clk),
		.we   (tab_we),
		.waddr(tab_waddr),
		.wdata({ref_q, size_q}),
		.raddr(tab_raddr),
		.rdata(data_rdata)
	);

	// status and result
	assign stat.idle            = (state_q == lrult_pkg::ST_IDLE);
	assign stat.done            = (state_q == lrult_pkg::ST_DONE);
	assign result.hit           = hit_q;
	assign result.found_ref     = fref_q;
	assign result.found_size    = fsize_q;
	assign result.evicted_count = evict_q;
	assign result.entries_held  = count_q;

endmodule

`default_nettype wire

// ----- design/lrult_chk.sv -----
// lrult_chk: port checker for the lru lookup table and its bind
`default_nettype none

module lrult_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_hit,
	input logic [31:0] rsp_found_ref,
	input logic [31:0] rsp_found_size,
	input logic [7:0]  rsp_evicted_count,
	input logic [7:0]  rsp_entries_held
);

	// stalled response beat holds valid, hit, found_ref, found_size and entries_held
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
			&& $stable(rsp_found_ref) && $stable(rsp_found_size)
			&& $stable(rsp_entries_held))
		else $error("response beat changed while stalled");

	// one item at a time: busy right after a request beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an item is in progress");

	// a hit implies a non-empty table
	a_hit_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_hit |-> rsp_entries_held != 8'd0)
		else $error("hit reported with an empty table");

	// miss or insert carries no content
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_hit |-> rsp_found_ref == 32'd0 && rsp_found_size == 32'd0)
		else $error("content reported without a hit");

	// only inserts evict
	a_evict_insert: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_evicted_count != 8'd0 |-> !rsp_hit && rsp_entries_held != 8'd0)
		else $error("eviction reported on a lookup");

endmodule

bind lru_lookup_table lrult_chk u_lrult_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_hit          (rsp.hit),
	.rsp_found_ref    (rsp.found_ref),
	.rsp_found_size   (rsp.found_size),
	.rsp_evicted_count(rsp.evicted_count),
	.rsp_entries_held (rsp.entries_held)
);

`default_nettype wire
